@@ hw/rtl/msobs_pkg.sv @@
// Shared constants, payload types and controller encodings for the max-subarray engine.
`default_nettype none

package msobs_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ID_W       = $clog2(MAX_BLOCKS);
    localparam int VALUE_W    = 16;
    localparam int BID_W      = 6;
    localparam int SUM_W      = 32;
    localparam int SEQ_W      = 64;

    localparam logic OPC_LOAD  = 1'b0;
    localparam logic OPC_INDEX = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic signed [VALUE_W-1:0] value;
        logic [BID_W-1:0]          block_id;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic signed [SEQ_W-1:0] max_sum;
    } result_t;

    // one table row: the four per-block figures
    typedef struct packed {
        logic signed [SUM_W-1:0] total;
        logic signed [SUM_W-1:0] prefix;
        logic signed [SUM_W-1:0] suffix;
        logic signed [SUM_W-1:0] inner;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_COMB
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec_load;
        logic sum_index;
        logic comb_index;
    } cmd_t;

    typedef struct packed {
        logic opcode;
        logic last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/msobs_if.sv @@
// Valid/ready channel interfaces for the item and result streams.
`default_nettype none

interface msobs_item_if;
    logic              valid;
    logic              ready;
    msobs_pkg::item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface msobs_result_if;
    logic               valid;
    logic               ready;
    msobs_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/msobs_ctrl.sv @@
// Controller: sequences table read, load update and the two-step index combine.
`default_nettype none

module msobs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire msobs_pkg::status_t status,
    output msobs_pkg::cmd_t        cmd
);

    msobs_pkg::state_t state_reg;
    msobs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msobs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msobs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = msobs_pkg::S_READ;
                end
            end
            msobs_pkg::S_READ:
            begin
                if (status.opcode == msobs_pkg::OPC_LOAD)
                begin
                    state_next = msobs_pkg::S_IDLE;
                end
                else
                begin
                    state_next = msobs_pkg::S_COMB;
                end
            end
            msobs_pkg::S_COMB:
            begin
                // a final index waits until the output register has room
                if (!status.last || status.out_free)
                begin
                    state_next = msobs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = msobs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            msobs_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            msobs_pkg::S_READ:
            begin
                cmd.exec_load = (status.opcode == msobs_pkg::OPC_LOAD);
                cmd.sum_index = (status.opcode == msobs_pkg::OPC_INDEX);
            end
            msobs_pkg::S_COMB:
            begin
                cmd.comb_index = !status.last || status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.exec_load, cmd.sum_index, cmd.comb_index}))
        else $error("more than one datapath command at once");

    a_capture_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == msobs_pkg::S_READ)
        else $error("captured beat not followed by table read");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.comb_index && status.last && !status.out_free))
        else $error("result emitted into a full output register");

    a_index_combines: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_index |=> state_reg == msobs_pkg::S_COMB)
        else $error("index sums not followed by combine");

endmodule

`default_nettype wire

@@ hw/rtl/msobs_dp.sv @@
// Datapath: block table, per-block load Kadane, sequence-level combine and output register.
`default_nettype none

module msobs_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire msobs_pkg::cmd_t   cmd,
    input  wire msobs_pkg::item_t  item_data,
    output msobs_pkg::status_t     status,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output msobs_pkg::result_t     out_data
);

    localparam int SW = msobs_pkg::SUM_W;
    localparam int QW = msobs_pkg::SEQ_W;

    localparam logic signed [SW-1:0] S32_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S32_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [QW-1:0] S64_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] S64_MIN = {1'b1, {(QW-1){1'b0}}};

    function automatic logic signed [SW-1:0] sat32(input logic signed [SW:0] x);
        if (x[SW] != x[SW-1])
        begin
            return x[SW] ? S32_MIN : S32_MAX;
        end
        return x[SW-1:0];
    endfunction

    function automatic logic signed [QW-1:0] sadd64(input logic signed [QW-1:0] a,
                                                     input logic signed [QW-1:0] b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        if (s[QW] != s[QW-1])
        begin
            return s[QW] ? S64_MIN : S64_MAX;
        end
        return s[QW-1:0];
    endfunction

    function automatic logic signed [QW-1:0] max64(input logic signed [QW-1:0] a,
                                                    input logic signed [QW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [QW-1:0] ext64(input logic signed [SW-1:0] a);
        return {{(QW-SW){a[SW-1]}}, a};
    endfunction

    // block table
    msobs_pkg::entry_t table_mem [msobs_pkg::MAX_BLOCKS];

    msobs_pkg::item_t  item_reg;
    msobs_pkg::entry_t rd_reg;

    logic signed [SW-1:0] load_sum_reg,  load_sum_next;
    logic signed [SW-1:0] load_minp_reg, load_minp_next;
    logic signed [SW-1:0] load_kend_reg, load_kend_next;
    logic                 load_first_reg, load_first_next;

    logic signed [QW-1:0] seq_end_reg,  seq_end_next;
    logic signed [QW-1:0] seq_ans_reg,  seq_ans_next;
    logic                 seq_first_reg, seq_first_next;

    logic signed [QW-1:0] sum_pre_reg;
    logic signed [QW-1:0] sum_tot_reg;

    logic                 out_valid_reg, out_valid_next;
    logic signed [QW-1:0] out_sum_reg;

    logic                 id_ok;
    logic [msobs_pkg::ID_W-1:0] cap_idx;
    logic [msobs_pkg::ID_W-1:0] cur_idx;

    logic signed [SW-1:0] v32;
    logic signed [SW:0]   run_wide;
    logic signed [SW:0]   kadd_wide;
    logic signed [SW:0]   kmax_wide;
    logic signed [SW-1:0] run;
    logic signed [SW-1:0] minp;
    logic signed [SW-1:0] kend;
    msobs_pkg::entry_t    wr_entry;

    logic signed [QW-1:0] inn64;
    logic signed [QW-1:0] suf64;

    assign cap_idx = item_data.block_id[msobs_pkg::ID_W-1:0];
    assign cur_idx = item_reg.block_id[msobs_pkg::ID_W-1:0];
    assign id_ok   = (32'(item_reg.block_id) < msobs_pkg::MAX_BLOCKS);

    assign status.opcode   = item_reg.opcode;
    assign status.last     = item_reg.last;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_data.max_sum = out_sum_reg;

    // per-element Kadane on the block being loaded
    always_comb
    begin
        v32       = {{(SW-msobs_pkg::VALUE_W){item_reg.value[msobs_pkg::VALUE_W-1]}},
                     item_reg.value};
        run_wide  = {load_sum_reg[SW-1], load_sum_reg} + {v32[SW-1], v32};
        kadd_wide = {load_kend_reg[SW-1], load_kend_reg} + {v32[SW-1], v32};
        kmax_wide = (kadd_wide > $signed({v32[SW-1], v32})) ? kadd_wide : {v32[SW-1], v32};
        if (load_first_reg)
        begin
            run             = v32;
            minp            = '0;
            kend            = v32;
            wr_entry.prefix = v32;
            wr_entry.inner  = v32;
        end
        else
        begin
            run             = sat32(run_wide);
            minp            = load_minp_reg;
            kend            = sat32(kmax_wide);
            wr_entry.prefix = (run > rd_reg.prefix) ? run : rd_reg.prefix;
            wr_entry.inner  = (kend > rd_reg.inner) ? kend : rd_reg.inner;
        end
        wr_entry.total  = run;
        wr_entry.suffix = sat32({run[SW-1], run} - {minp[SW-1], minp});

        load_sum_next   = load_sum_reg;
        load_minp_next  = load_minp_reg;
        load_kend_next  = load_kend_reg;
        load_first_next = load_first_reg;
        if (cmd.exec_load && id_ok)
        begin
            if (item_reg.last)
            begin
                load_sum_next   = '0;
                load_minp_next  = '0;
                load_kend_next  = '0;
                load_first_next = 1'b1;
            end
            else
            begin
                load_sum_next   = run;
                load_minp_next  = (run < minp) ? run : minp;
                load_kend_next  = kend;
                load_first_next = 1'b0;
            end
        end
    end

    // block-level Kadane over the index sequence
    always_comb
    begin
        inn64 = ext64(rd_reg.inner);
        suf64 = ext64(rd_reg.suffix);

        seq_end_next   = seq_end_reg;
        seq_ans_next   = seq_ans_reg;
        seq_first_next = seq_first_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.comb_index)
        begin
            if (id_ok)
            begin
                if (seq_first_reg)
                begin
                    seq_ans_next   = max64(seq_ans_reg, inn64);
                    seq_end_next   = suf64;
                    seq_first_next = 1'b0;
                end
                else
                begin
                    seq_ans_next = max64(seq_ans_reg, max64(inn64, sum_pre_reg));
                    seq_end_next = max64(suf64, sum_tot_reg);
                end
            end
            if (item_reg.last)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_reg <= table_mem[cap_idx];
        end
        if (cmd.exec_load && id_ok)
        begin
            table_mem[cur_idx] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item_data;
        end
        if (cmd.sum_index)
        begin
            sum_pre_reg <= sadd64(seq_end_reg, ext64(rd_reg.prefix));
            sum_tot_reg <= sadd64(seq_end_reg, ext64(rd_reg.total));
        end
        if (cmd.comb_index && item_reg.last)
        begin
            out_sum_reg <= seq_ans_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_sum_reg   <= '0;
            load_minp_reg  <= '0;
            load_kend_reg  <= '0;
            load_first_reg <= 1'b1;
            seq_end_reg    <= S64_MIN;
            seq_ans_reg    <= S64_MIN;
            seq_first_reg  <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            load_sum_reg   <= load_sum_next;
            load_minp_reg  <= load_minp_next;
            load_kend_reg  <= load_kend_next;
            load_first_reg <= load_first_next;
            out_valid_reg  <= out_valid_next;
            if (cmd.comb_index && item_reg.last)
            begin
                seq_end_reg   <= S64_MIN;
                seq_ans_reg   <= S64_MIN;
                seq_first_reg <= 1'b1;
            end
            else
            begin
                seq_end_reg   <= seq_end_next;
                seq_ans_reg   <= seq_ans_next;
                seq_first_reg <= seq_first_next;
            end
        end
    end

    a_seq_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.comb_index && item_reg.last |=> seq_first_reg && seq_ans_reg == S64_MIN)
        else $error("sequence state not cleared after final index");

    a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec_load && id_ok && item_reg.last |=> load_first_reg && load_sum_reg == '0)
        else $error("load state not cleared after final element");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.comb_index && item_reg.last |=> out_valid_reg)
        else $error("final index produced no result");

endmodule

`default_nettype wire

@@ hw/rtl/max_subarray_over_block_sequence.sv @@
// Top level: maximum contiguous sum over a sequence of stored blocks.
//
//   channel   dir   payload                                 beat when
//   item      in    opcode, value[15:0], block_id[5:0], last  valid && ready
//   result    out   max_sum[63:0] (signed, saturated)       valid && ready
//
// A load beat passes through the registered table read, then the load update and
// table write; an index beat through the table read, a 64-bit saturating add,
// then compare/select. A new beat is accepted only when the previous one is done.
// Reset (rst_n, asynchronous) clears load and sequence state; the block table
// holds nothing defined until its entries are loaded.
// A final index stalls in its combine step while a previous result is not taken;
// other beats proceed past a waiting result.
`default_nettype none

module max_subarray_over_block_sequence (
    input  wire logic      clk,
    input  wire logic      rst_n,
    msobs_item_if.sink     item,
    msobs_result_if.source result
);

    msobs_pkg::cmd_t    cmd;
    msobs_pkg::status_t status;

    msobs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    msobs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item_data (item.data),
        .status    (status),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result.data)
    );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Randomized self-checking bench for the block-sequence max contiguous sum engine.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CYCLE_LIMIT = 250000;
    localparam int     RANDOM_BEATS = 1525;
    localparam int     TAIL_CYCLES = 20;
    localparam longint SEQ_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SEQ_MIN = 64'sh8000_0000_0000_0000;

    logic clk;
    logic rst_n;

    msobs_item_if   item_ch();
    msobs_result_if result_ch();

    max_subarray_over_block_sequence uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stimulus and scoreboard storage
    msobs_pkg::item_t pending_items[$];
    longint expected_max_sums[$];
    int     beats_total;
    int     beats_accepted;
    int     fail_count;
    int     cycle_count;

    // shadow of the block table and the two running Kadane states
    int     tbl_total[msobs_pkg::MAX_BLOCKS];
    int     tbl_prefix[msobs_pkg::MAX_BLOCKS];
    int     tbl_suffix[msobs_pkg::MAX_BLOCKS];
    int     tbl_inner[msobs_pkg::MAX_BLOCKS];
    int     ld_sum;
    int     ld_min_prefix;
    int     ld_kend;
    bit     ld_first;
    longint run_best_end;
    longint run_answer;
    bit     run_first;

    // generator bookkeeping: which blocks hold defined entries
    bit     block_loaded[msobs_pkg::MAX_BLOCKS];
    int     loaded_ids[$];
    bit     gen_open;
    int     gen_open_id;

    function automatic int clamp32(longint x);
        if (x > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (x < -longint'(32'sh7FFF_FFFF) - 1)
            return 32'sh8000_0000;
        return int'(x);
    endfunction

    function automatic longint add_sat64(longint a, longint b);
        if (b > 0 && a > SEQ_MAX - b)
            return SEQ_MAX;
        if (b < 0 && a < SEQ_MIN - b)
            return SEQ_MIN;
        return a + b;
    endfunction

    function automatic longint max64(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    task automatic clear_sequence();
        run_best_end = SEQ_MIN;
        run_answer   = SEQ_MIN;
        run_first    = 1'b1;
    endtask

    task automatic clear_load();
        ld_sum        = 0;
        ld_min_prefix = 0;
        ld_kend       = 0;
        ld_first      = 1'b1;
    endtask

    task automatic predict_max_sum(input msobs_pkg::item_t it);
        longint v;
        longint k;
        longint cand;
        int     id;
        int     run;
        int     pre;
        int     inn;
        int     kend;
        int     minp;
        v  = longint'($signed(it.value));
        id = int'(it.block_id);
        if (it.opcode == msobs_pkg::OPC_LOAD)
        begin
            if (ld_first)
            begin
                run  = clamp32(v);
                minp = 0;
                pre  = run;
                kend = run;
                inn  = run;
            end
            else
            begin
                run  = clamp32(longint'(ld_sum) + v);
                minp = ld_min_prefix;
                pre  = tbl_prefix[id];
                if (run > pre)
                    pre = run;
                k    = longint'(ld_kend) + v;
                kend = clamp32(max64(k, v));
                inn  = tbl_inner[id];
                if (kend > inn)
                    inn = kend;
            end
            tbl_total[id]  = run;
            tbl_prefix[id] = pre;
            tbl_inner[id]  = inn;
            tbl_suffix[id] = clamp32(longint'(run) - longint'(minp));
            if (it.last)
                clear_load();
            else
            begin
                ld_sum        = run;
                ld_min_prefix = (run < minp) ? run : minp;
                ld_kend       = kend;
                ld_first      = 1'b0;
            end
        end
        else
        begin
            if (run_first)
            begin
                run_answer   = max64(run_answer, longint'(tbl_inner[id]));
                run_best_end = longint'(tbl_suffix[id]);
                run_first    = 1'b0;
            end
            else
            begin
                cand = max64(longint'(tbl_inner[id]),
                             add_sat64(run_best_end, longint'(tbl_prefix[id])));
                run_answer   = max64(run_answer, cand);
                run_best_end = max64(longint'(tbl_suffix[id]),
                                     add_sat64(run_best_end, longint'(tbl_total[id])));
            end
            if (it.last)
            begin
                expected_max_sums = {expected_max_sums, run_answer};
                clear_sequence();
            end
        end
    endtask

    task automatic push_load(input int id, input int v, input bit last);
        msobs_pkg::item_t it;
        it.opcode   = msobs_pkg::OPC_LOAD;
        it.value    = v[15:0];
        it.block_id = id[5:0];
        it.last     = last;
        pending_items = {pending_items, it};
        if (!block_loaded[id])
        begin
            block_loaded[id] = 1'b1;
            loaded_ids = {loaded_ids, id};
        end
        gen_open    = !last;
        gen_open_id = id;
    endtask

    task automatic push_index(input int id, input bit last);
        msobs_pkg::item_t it;
        it.opcode   = msobs_pkg::OPC_INDEX;
        it.value    = 16'($urandom);
        it.block_id = id[5:0];
        it.last     = last;
        pending_items = {pending_items, it};
    endtask

    function automatic int pick_loaded();
        return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
    endfunction

    // a non-first element reads the stored row, so it must name a defined block
    function automatic int next_load_id();
        return gen_open ? gen_open_id : int'($urandom_range(0, msobs_pkg::MAX_BLOCKS - 1));
    endfunction

    function automatic int pick_value();
        case ($urandom_range(0, 4))
            0:       return int'($signed(16'($urandom)));
            1:       return int'($urandom_range(0, 200)) - 100;
            2:       return $urandom_range(0, 1) ? 32767 : -32768;
            3:       return int'($urandom_range(0, 2000)) - 1000;
            default: return int'($urandom_range(0, 60)) - 20;
        endcase
    endfunction

    task automatic build_directed();
        push_load(0, 32767, 0);
        push_load(0, -32768, 0);
        push_load(0, 5, 1);
        push_load(63, -32768, 1);
        push_load(1, -3, 0);
        push_load(1, 10, 0);
        push_load(1, -1, 0);
        push_load(1, 4, 1);
        push_index(0, 1);
        push_index(63, 1);
        push_index(0, 0);
        push_index(63, 0);
        push_index(1, 1);
        // load that hops to another block before its last element
        push_load(2, 7, 0);
        push_load(0, -2, 0);
        push_load(2, -9, 1);
        // index a block that is still being loaded
        push_load(3, 100, 0);
        push_index(3, 1);
        push_load(3, -50, 0);
        push_index(3, 0);
        push_index(1, 0);
        push_index(3, 1);
        push_load(3, 20, 1);
    endtask

    task automatic build_random();
        int start;
        int len;
        int sel;
        start = pending_items.size();
        while (pending_items.size() - start < RANDOM_BEATS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 38)
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    push_load(next_load_id(), pick_value(), i == len - 1);
            end
            else if (sel < 80)
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        push_load(next_load_id(), pick_value(), 1'($urandom_range(0, 1)));
                    push_index(pick_loaded(), i == len - 1);
                end
            end
            else if (sel < 90)
            begin
                // partial block left open
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    push_load(next_load_id(), pick_value(), 1'b0);
            end
            else
            begin
                push_load(next_load_id(), pick_value(), 1'b0);
                push_load(pick_loaded(), pick_value(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // sender: bursts with random gaps, payload held while stalled
    int send_burst_left;
    int send_gap_left;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            send_burst_left = $urandom_range(1, 20);
            send_gap_left   = 0;
        end
        else if (!(item_ch.valid && !item_ch.ready))
        begin
            if (send_gap_left > 0)
            begin
                send_gap_left--;
                item_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item_ch.data  <= pending_items.pop_front();
                item_ch.valid <= 1'b1;
                send_burst_left--;
                if (send_burst_left == 0)
                begin
                    send_burst_left = $urandom_range(1, 24);
                    send_gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // receiver: its own stall pattern plus a periodic long hold-off
    int rx_cycle;
    int rx_hold_left;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rx_cycle     = 0;
            rx_hold_left = 0;
        end
        else
        begin
            rx_cycle++;
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (rx_cycle % 3000 == 1500)
            begin
                rx_hold_left = 300;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 256) % 4)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= (rx_cycle % 8 != 0);
                    default: result_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // monitor: predict on each input beat, check each result beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predict_max_sum(item_ch.data);
                beats_accepted++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_max_sums.size() == 0)
                begin
                    $display("%0t: unexpected result beat max_sum=%0d", $realtime,
                             $signed(result_ch.data.max_sum));
                    fail_count++;
                end
                else
                begin
                    if (result_ch.data.max_sum !== expected_max_sums[0])
                    begin
                        $display("%0t: max_sum mismatch expected=%0d actual=%0d", $realtime,
                                 expected_max_sums[0], $signed(result_ch.data.max_sum));
                        fail_count++;
                    end
                    void'(expected_max_sums.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        beats_accepted  = 0;
        fail_count      = 0;
        cycle_count     = 0;
        gen_open        = 1'b0;
        gen_open_id     = 0;
        for (int i = 0; i < msobs_pkg::MAX_BLOCKS; i++)
        begin
            tbl_total[i]    = 0;
            tbl_prefix[i]   = 0;
            tbl_suffix[i]   = 0;
            tbl_inner[i]    = 0;
            block_loaded[i] = 1'b0;
        end
        clear_load();
        clear_sequence();

        build_directed();
        build_random();
        beats_total = pending_items.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (beats_accepted < beats_total)
            @(posedge clk);
        while (expected_max_sums.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/msobs_pkg.sv
hw/rtl/msobs_if.sv
hw/rtl/msobs_ctrl.sv
hw/rtl/msobs_dp.sv
hw/rtl/max_subarray_over_block_sequence.sv
test/testbench.sv
